// ===== rtl/core/sltm_pkg.sv =====
// ----------------------------------------------------------------------------
// sltm_pkg: shared types and constants for the schedule list parser
// Holds the list state record, mode constants and the range mask helpers.
// ----------------------------------------------------------------------------
package sltm_pkg;

  localparam int MASK_W = 31;

  localparam logic [MASK_W-1:0] DAY_ALL  = 31'h7FFF_FFFF;
  localparam logic [MASK_W-1:0] HOUR_ALL = 31'h00FF_FFFF;
  localparam logic [MASK_W-1:0] HOUR_DEF = 31'h0000_0001;
  localparam logic [4:0]        DAY_TOP  = 5'd30;
  localparam logic [4:0]        HOUR_TOP = 5'd23;

  localparam logic MODE_DAY  = 1'b0;
  localparam logic MODE_HOUR = 1'b1;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] ACC_MAX = 8'd255;

  typedef struct packed {
    logic [MASK_W-1:0] sel;
    logic [7:0]        acc;
    logic              in_number;
    logic              range_pending;
    logic [5:0]        last_pos;
    logic              seen;
  } list_t;

  localparam list_t LIST_CLEAR = '{sel: '0, acc: '0, in_number: 1'b0,
                                   range_pending: 1'b0, last_pos: '0, seen: 1'b0};

  // Bits lo..hi inclusive; empty when lo > hi
  function automatic logic [MASK_W-1:0] span(logic [5:0] lo, logic [4:0] hi);
    logic [31:0] upper;
    logic [31:0] lower;
    logic [31:0] both;
    upper = (32'd2 << hi) - 32'd1;
    lower = (32'd1 << lo) - 32'd1;
    both  = upper & ~lower;
    return both[MASK_W-1:0];
  endfunction

  // Close an open digit run: single value or end of a pending range
  function automatic list_t end_num(list_t s, logic [7:0] acc, logic mode);
    logic       neg;
    logic [7:0] n;
    logic [4:0] top;
    logic [4:0] nc;
    list_t      r;
    r           = s;
    top         = (mode == MODE_HOUR) ? HOUR_TOP : DAY_TOP;
    neg         = (mode == MODE_DAY) && (acc == 8'd0);
    n           = (mode == MODE_HOUR) ? acc : acc - 8'd1;
    r.in_number = 1'b0;
    r.acc       = 8'd0;
    if (s.range_pending) begin
      if (!neg) begin
        nc = (n > {3'b000, top}) ? top : n[4:0];
        if (s.last_pos <= {1'b0, nc}) begin
          r.sel      = s.sel | span(s.last_pos, nc);
          r.last_pos = {1'b0, nc} + 6'd1;
        end
      end
      r.range_pending = 1'b0;
      r.seen          = 1'b1;
    end else if (!neg && (n <= {3'b000, top})) begin
      r.sel      = s.sel | (MASK_W'(1) << n[4:0]);
      r.last_pos = {1'b0, n[4:0]};
      r.seen     = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/schedule_list_to_mask_parser.sv =====
// ----------------------------------------------------------------------------
// schedule_list_to_mask_parser: cron-style list to selection mask
// Latency: the mask of a list is valid in the cycle after its last beat.
// Throughput: one character beat per cycle unless a mask waits untaken;
// list state and mask registers update in one short combinational pass.
// Reset: synchronous; clears the list state and the mask valid flag and
// sets the mode register to day of month. No clearing pass is needed.
// ----------------------------------------------------------------------------
module schedule_list_to_mask_parser
  import sltm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              field_mode,
  // character beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        ch,
  input  logic              last,
  // mask beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] mask
);

  logic              mode;
  list_t             st;
  list_t             st_next;
  list_t             work;
  logic              accept;
  logic              is_digit;
  logic [3:0]        digit;
  logic [11:0]       acc_wide;
  logic [7:0]        acc_eff;
  logic              end_now;
  logic [4:0]        top;
  logic [MASK_W-1:0] all_bits;
  logic [MASK_W-1:0] result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_DAY;
    end else if (cfg_valid && cfg_ready) begin
      mode <= field_mode;
    end
  end

  // Decode the character and form the digit accumulation before saturation
  always_comb begin
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit    = 4'(ch - CH_ZERO);
    acc_wide = {1'b0, st.acc, 3'b000} + {3'b000, st.acc, 1'b0} + {8'd0, digit};
    top      = (mode == MODE_HOUR) ? HOUR_TOP : DAY_TOP;
    all_bits = (mode == MODE_HOUR) ? HOUR_ALL : DAY_ALL;
  end

  // Advance the list state for one character
  always_comb begin
    work    = st;
    acc_eff = st.acc;
    if (is_digit) begin
      acc_eff        = (acc_wide > {4'd0, ACC_MAX}) ? ACC_MAX : acc_wide[7:0];
      work.acc       = acc_eff;
      work.in_number = 1'b1;
      end_now        = last;
    end else begin
      end_now = st.in_number;
    end
    if (end_now) begin
      work = end_num(work, acc_eff, mode);
    end
    if (!is_digit && (ch == CH_STAR)) begin
      work.sel  = all_bits;
      work.seen = 1'b1;
    end
    if (!is_digit && (ch == CH_DASH)) begin
      work.range_pending = 1'b1;
    end
  end

  // Finish the mask: trailing range, default, mode width
  always_comb begin
    if (work.range_pending) begin
      result = work.sel;
      if (work.last_pos <= {1'b0, top}) begin
        result = work.sel | span(work.last_pos, top);
      end
    end else if (!work.seen) begin
      result = (mode == MODE_HOUR) ? HOUR_DEF : DAY_ALL;
    end else begin
      result = work.sel;
    end
    result = result & all_bits;
  end

  always_comb begin
    st_next = st;
    if (accept) begin
      st_next = last ? LIST_CLEAR : work;
    end
  end

  // Hold the list state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= LIST_CLEAR;
    end else begin
      st <= st_next;
    end
  end

  // Load the mask register on the last beat, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      mask <= result;
    end
  end

`ifndef SYNTHESIS
  a_last_gives_mask : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> out_valid)
    else $error("last beat did not load a mask");

  a_list_cleared : assert property (@(posedge clk) disable iff (rst)
    accept && last |=> (st.sel == '0) && !st.in_number && !st.range_pending && !st.seen)
    else $error("list state not cleared after last beat");

  a_hour_width : assert property (@(posedge clk) disable iff (rst)
    accept && last && (mode == MODE_HOUR) |=> (mask[MASK_W-1:24] == '0))
    else $error("hour mask has bits above the top hour");

  a_acc_open : assert property (@(posedge clk) disable iff (rst)
    (st.acc != 8'd0) |-> st.in_number)
    else $error("accumulator holds a value with no open digit run");

  a_last_pos : assert property (@(posedge clk) disable iff (rst)
    st.last_pos <= 6'd31)
    else $error("range start beyond the mask");
`endif

endmodule
